### rtl/i2cbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Types, codes and constants shared by the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

  localparam int CMD_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int POLL_W  = 8;

  localparam logic [POLL_W-1:0] ACK_POLL_LIMIT_RST = POLL_W'(250);
  localparam logic [BYTE_W-1:0] MSB_MASK           = 8'h80;

  localparam logic [CMD_W-1:0] CMD_PROBE = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    ACT_IDLE          = 4'd0,
    ACT_START         = 4'd1,
    ACT_STOP          = 4'd2,
    ACT_WRITE         = 4'd3,
    ACT_READ          = 4'd4,
    ACT_ACK           = 4'd5,
    ACT_NACK          = 4'd6,
    ACT_WAIT          = 4'd7,
    ACT_PRB_START     = 4'd9,
    ACT_PRB_WRITE     = 4'd10,
    ACT_PRB_WAIT      = 4'd11,
    ACT_PRB_STOP      = 4'd12,
    ACT_FAIL_STOP     = 4'd13,
    ACT_PRB_FAIL_STOP = 4'd14
  } act_t;

  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_START = 3'd1,
    K_STOP  = 3'd2,
    K_WRITE = 3'd3,
    K_READ  = 3'd4,
    K_ACK   = 3'd5,
    K_NACK  = 3'd6,
    K_WAIT  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    R_CONT = 2'd0,
    R_FIN  = 2'd1,
    R_FAIL = 2'd2
  } prim_res_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_pull_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              ack_missing;
  } result_t;

  function automatic kind_t kind_of(input logic [CMD_W-1:0] a);
    kind_t k;
    case (a)
      ACT_START, ACT_PRB_START:                       k = K_START;
      ACT_STOP, ACT_PRB_STOP, ACT_FAIL_STOP,
      ACT_PRB_FAIL_STOP:                              k = K_STOP;
      ACT_WRITE, ACT_PRB_WRITE:                       k = K_WRITE;
      ACT_READ:                                       k = K_READ;
      ACT_ACK:                                        k = K_ACK;
      ACT_NACK:                                       k = K_NACK;
      ACT_WAIT, ACT_PRB_WAIT:                         k = K_WAIT;
      default:                                        k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

### rtl/i2cbs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbs interfaces
// Valid/ready channels for tick words, result words and configuration.
// ----------------------------------------------------------------------------
interface i2cbs_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] cmd;
  logic [7:0] write_data;
  logic       sda_in;
  modport source (output valid, cmd, write_data, sda_in, input ready);
  modport sink   (input valid, cmd, write_data, sda_in, output ready);
endinterface

interface i2cbs_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_missing;
  modport source (output valid, scl_level, sda_pull_low, busy_res, done_res,
                  read_byte, ack_missing, input ready);
  modport sink   (input valid, scl_level, sda_pull_low, busy_res, done_res,
                  read_byte, ack_missing, output ready);
endinterface

interface i2cbs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/i2cbs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbs_core
// Bus sequencer state: advances one phase of the active command per tick.
// ----------------------------------------------------------------------------
module i2cbs_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [i2cbs_pkg::CMD_W-1:0]   cmd,
  input  logic [i2cbs_pkg::BYTE_W-1:0]  write_data,
  input  logic                          sda_in,
  input  logic [i2cbs_pkg::POLL_W-1:0]  ack_poll_limit,
  output i2cbs_pkg::result_t            res
);
  import i2cbs_pkg::*;

  act_t              active_r, active_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [POLL_W-1:0] poll_r, poll_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_low_r, sda_low_nxt;
  logic              no_ack_r, no_ack_nxt;
  logic [BYTE_W-1:0] read_hold_r, read_hold_nxt;

  always_comb begin
    act_t      act;
    kind_t     kind;
    prim_res_t r;
    act_t      nxt_act;
    act           = active_r;
    phase_nxt     = phase_r;
    bit_nxt       = bit_r;
    shift_nxt     = shift_r;
    poll_nxt      = poll_r;
    scl_nxt       = scl_r;
    sda_low_nxt   = sda_low_r;
    no_ack_nxt    = no_ack_r;
    read_hold_nxt = read_hold_r;
    r             = R_CONT;
    nxt_act       = ACT_IDLE;
    res.done_res  = 1'b0;

    if (kind_of(act) == K_NONE) begin
      act = ACT_IDLE;
    end
    if (act == ACT_IDLE && cmd >= ACT_START && cmd <= CMD_PROBE) begin
      act       = (cmd == CMD_PROBE) ? ACT_PRB_START : act_t'(cmd);
      phase_nxt = 2'd0;
      bit_nxt   = 3'd0;
      poll_nxt  = '0;
      shift_nxt = write_data;
    end
    kind = kind_of(act);

    case (kind)
      K_START: begin
        if (phase_nxt == 2'd0) begin
          sda_low_nxt = 1'b0; scl_nxt = 1'b1; phase_nxt = 2'd1;
        end else if (phase_nxt == 2'd1) begin
          sda_low_nxt = 1'b1; phase_nxt = 2'd2;
        end else begin
          scl_nxt = 1'b0; r = R_FIN;
        end
      end
      K_STOP: begin
        if (phase_nxt == 2'd0) begin
          scl_nxt = 1'b0; sda_low_nxt = 1'b1; phase_nxt = 2'd1;
        end else if (phase_nxt == 2'd1) begin
          scl_nxt = 1'b1; phase_nxt = 2'd2;
        end else begin
          sda_low_nxt = 1'b0; r = R_FIN;
        end
      end
      K_WRITE: begin
        if (phase_nxt == 2'd0) begin
          scl_nxt = 1'b0; phase_nxt = 2'd1;
        end else if (phase_nxt == 2'd1) begin
          sda_low_nxt = ((shift_nxt & MSB_MASK) == '0);
          phase_nxt   = 2'd2;
        end else if (phase_nxt == 2'd2) begin
          scl_nxt = 1'b1; phase_nxt = 2'd3;
        end else begin
          scl_nxt = 1'b0;
          if (bit_nxt == 3'd7) begin
            sda_low_nxt = 1'b0; r = R_FIN;
          end else begin
            bit_nxt   = bit_nxt + 3'd1;
            shift_nxt = {shift_nxt[BYTE_W-2:0], 1'b0};
            phase_nxt = 2'd1;
          end
        end
      end
      K_READ: begin
        if (phase_nxt == 2'd0) begin
          scl_nxt = 1'b0; sda_low_nxt = 1'b0; phase_nxt = 2'd1;
        end else begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_nxt[BYTE_W-2:0], sda_in};
          if (bit_nxt == 3'd7) begin
            read_hold_nxt = shift_nxt; r = R_FIN;
          end else begin
            bit_nxt   = bit_nxt + 3'd1;
            phase_nxt = 2'd0;
          end
        end
      end
      K_ACK, K_NACK: begin
        if (phase_nxt == 2'd0) begin
          scl_nxt = 1'b0; sda_low_nxt = (kind == K_ACK); phase_nxt = 2'd1;
        end else if (phase_nxt == 2'd1) begin
          scl_nxt = 1'b1; phase_nxt = 2'd2;
        end else begin
          scl_nxt = 1'b0; r = R_FIN;
        end
      end
      K_WAIT: begin
        if (phase_nxt == 2'd0) begin
          sda_low_nxt = 1'b0; phase_nxt = 2'd1;
        end else if (phase_nxt == 2'd1) begin
          scl_nxt = 1'b1; phase_nxt = 2'd2;
        end else if (!sda_in) begin
          scl_nxt = 1'b0; no_ack_nxt = 1'b0; r = R_FIN;
        end else if (poll_nxt >= ack_poll_limit) begin
          no_ack_nxt = 1'b1; r = R_FAIL;
        end else begin
          poll_nxt = poll_nxt + POLL_W'(1);
        end
      end
      default: begin
      end
    endcase

    if (r == R_FIN) begin
      case (act)
        ACT_PRB_START:     nxt_act = ACT_PRB_WRITE;
        ACT_PRB_WRITE:     nxt_act = ACT_PRB_WAIT;
        ACT_PRB_WAIT:      nxt_act = ACT_PRB_STOP;
        ACT_PRB_FAIL_STOP: nxt_act = ACT_PRB_STOP;
        default:           nxt_act = ACT_IDLE;
      endcase
    end else if (r == R_FAIL) begin
      nxt_act = (act == ACT_PRB_WAIT) ? ACT_PRB_FAIL_STOP : ACT_FAIL_STOP;
    end
    if (r != R_CONT) begin
      act       = nxt_act;
      phase_nxt = 2'd0;
      bit_nxt   = 3'd0;
      poll_nxt  = '0;
      res.done_res = (nxt_act == ACT_IDLE);
    end
    active_nxt = act;

    res.scl_level    = scl_nxt;
    res.sda_pull_low = sda_low_nxt;
    res.busy_res     = (act != ACT_IDLE);
    res.read_byte    = read_hold_nxt;
    res.ack_missing  = no_ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACT_IDLE;
      phase_r     <= 2'd0;
      bit_r       <= 3'd0;
      shift_r     <= '0;
      poll_r      <= '0;
      scl_r       <= 1'b1;
      sda_low_r   <= 1'b0;
      no_ack_r    <= 1'b0;
      read_hold_r <= '0;
    end else if (step) begin
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      poll_r      <= poll_nxt;
      scl_r       <= scl_nxt;
      sda_low_r   <= sda_low_nxt;
      no_ack_r    <= no_ack_nxt;
      read_hold_r <= read_hold_nxt;
    end
  end

endmodule

### rtl/i2c_master_bit_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top
// I2C master that advances its SCL/SDA sequence by one tick per input word.
//
//   channel  | dir | word
//   in_ch    | in  | cmd, write_data, sda_in
//   out_ch   | out | scl_level, sda_pull_low, busy_res, done_res, read_byte,
//            |     | ack_missing
//   cfg_ch   | in  | ack_poll_limit
//
// One word per cycle unless stalled; each accepted word yields its result word in
// the next cycle from the output register. The input stalls only while that
// register is full and not being taken. Reset is synchronous and returns SCL
// and SDA to released, with ack_poll_limit at 250. Configuration is always ready.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top (
  input  logic           clk,
  input  logic           rst_n,
  i2cbs_in_if.sink       in_ch,
  i2cbs_out_if.source    out_ch,
  i2cbs_cfg_if.sink      cfg_ch
);
  import i2cbs_pkg::*;

  logic [POLL_W-1:0] ack_poll_limit_r;
  logic              out_valid_r;
  result_t           res_r;
  result_t           res_nxt;
  logic              accept;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  i2cbs_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (accept),
    .cmd            (in_ch.cmd),
    .write_data     (in_ch.write_data),
    .sda_in         (in_ch.sda_in),
    .ack_poll_limit (ack_poll_limit_r),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_poll_limit_r <= ACK_POLL_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      ack_poll_limit_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scl_level    = res_r.scl_level;
  assign out_ch.sda_pull_low = res_r.sda_pull_low;
  assign out_ch.busy_res     = res_r.busy_res;
  assign out_ch.done_res     = res_r.done_res;
  assign out_ch.read_byte    = res_r.read_byte;
  assign out_ch.ack_missing  = res_r.ack_missing;

endmodule
